FILE: rtl/core/rxpqt_pkg.sv
// Shared constants and types for the range XOR point query tree.
// Field widths, action codes and the op record between sequencer and datapath.
// No dependencies.
package rxpqt_pkg;

  localparam int unsigned LEAVES_DEF = 1024;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned RB_W     = 10;
  localparam int unsigned RE_W     = 11;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned USED_W   = 11;
  localparam int unsigned BND_W    = 18;

  localparam logic [USED_W-1:0] USED_RST = 11'd1024;

  localparam logic [ACTION_W-1:0] ACT_APPLY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    OP_PATH,
    OP_SIB,
    OP_END,
    OP_SET,
    OP_GET,
    OP_ZERO,
    OP_VAL
  } op_kind_e;

  typedef struct packed {
    logic     vld;
    op_kind_e kind;
    logic     clr;
  } op_ctl_t;

endpackage

FILE: rtl/core/rxpqt_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on rxpqt_pkg for field widths.
interface rxpqt_req_if;
  logic                             valid;
  logic                             ready;
  logic [rxpqt_pkg::ACTION_W-1:0]   action;
  logic [rxpqt_pkg::RB_W-1:0]       range_begin;
  logic [rxpqt_pkg::RE_W-1:0]       range_end;
  logic [rxpqt_pkg::IDX_W-1:0]      index;
  logic [rxpqt_pkg::VALUE_W-1:0]    value;

  modport source(output valid, action, range_begin, range_end, index, value, input ready);
  modport sink(input valid, action, range_begin, range_end, index, value, output ready);
endinterface

interface rxpqt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rxpqt_pkg::VALUE_W-1:0]    read_value;
  logic                             status;

  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

FILE: rtl/core/rxpqt_mem.sv
// Node tag memory: one write and one registered read per cycle.
// Forwards a write that lands on the address read in the same cycle.
// Depends on rxpqt_pkg.
module rxpqt_mem #(
  parameter int unsigned NODE_W = $clog2(rxpqt_pkg::LEAVES_DEF) + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [NODE_W-1:0]               waddr_i,
  input  logic [rxpqt_pkg::VALUE_W-1:0]   wdata_i,
  input  logic [NODE_W-1:0]               raddr_i,
  output logic [rxpqt_pkg::VALUE_W-1:0]   rdata_o
);

  localparam int unsigned DEPTH = 1 << NODE_W;

  logic [rxpqt_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [rxpqt_pkg::VALUE_W-1:0] rdata_q;
  logic [rxpqt_pkg::VALUE_W-1:0] byp_data_q;
  logic                          byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem_q[raddr_i];
    byp_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rdata_q;

endmodule

FILE: rtl/core/rxpqt_exec.sv
// Read-modify-write datapath: applies one op per cycle to the tag read back,
// carries the pushed-down tag along a path and captures the point value.
// Depends on rxpqt_pkg.
module rxpqt_exec #(
  parameter int unsigned NODE_W = $clog2(rxpqt_pkg::LEAVES_DEF) + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rxpqt_pkg::op_ctl_t              op_i,
  input  logic [NODE_W-1:0]               addr_i,
  input  logic [rxpqt_pkg::VALUE_W-1:0]   value_i,
  input  logic [rxpqt_pkg::VALUE_W-1:0]   rdata_i,
  output logic                            we_o,
  output logic [NODE_W-1:0]               waddr_o,
  output logic [rxpqt_pkg::VALUE_W-1:0]   wdata_o,
  output logic [rxpqt_pkg::VALUE_W-1:0]   read_value_o
);

  rxpqt_pkg::op_ctl_t              op_q;
  logic [NODE_W-1:0]               addr_q;
  logic [rxpqt_pkg::VALUE_W-1:0]   acc_q, acc_d;
  logic [rxpqt_pkg::VALUE_W-1:0]   read_q, read_d;
  logic [rxpqt_pkg::VALUE_W-1:0]   mixed;

  assign mixed = rdata_i ^ acc_q;

  always_comb begin
    acc_d   = acc_q;
    read_d  = read_q;
    we_o    = op_q.vld;
    wdata_o = mixed;
    if (op_q.vld) begin
      case (op_q.kind)
        rxpqt_pkg::OP_PATH: begin
          acc_d   = mixed;
          wdata_o = '0;
        end
        rxpqt_pkg::OP_SIB: begin
          wdata_o = mixed;
        end
        rxpqt_pkg::OP_END: begin
          acc_d = '0;
        end
        rxpqt_pkg::OP_SET: begin
          wdata_o = value_i;
          acc_d   = '0;
        end
        rxpqt_pkg::OP_GET: begin
          read_d = mixed;
          acc_d  = '0;
        end
        rxpqt_pkg::OP_ZERO: begin
          wdata_o = '0;
          acc_d   = '0;
        end
        rxpqt_pkg::OP_VAL: begin
          wdata_o = rdata_i ^ value_i;
        end
        default: begin
          we_o = 1'b0;
        end
      endcase
    end
    if (op_i.clr) begin
      acc_d  = '0;
      read_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= '0;
      acc_q  <= '0;
      read_q <= '0;
    end else begin
      op_q   <= op_i;
      acc_q  <= acc_d;
      read_q <= read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
  end

  assign waddr_o      = addr_q;
  assign read_value_o = read_q;

endmodule

FILE: rtl/core/rxpqt_seq.sv
// Sequencer: checks bounds, clears the memory after reset and emits the node
// ops for the push walks, the leaf access and the range cover loop.
// Depends on rxpqt_pkg and rxpqt_req_if.
module rxpqt_seq #(
  parameter int unsigned LEAVES = rxpqt_pkg::LEAVES_DEF,
  parameter int unsigned NODE_W = $clog2(LEAVES) + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rxpqt_pkg::USED_W-1:0]    used_size_i,
  rxpqt_req_if.sink                       req_i,
  output rxpqt_pkg::op_ctl_t              op_o,
  output logic [NODE_W-1:0]               addr_o,
  output logic [rxpqt_pkg::VALUE_W-1:0]   value_o,
  output logic                            done_o,
  output logic                            status_o,
  input  logic                            load_i
);

  localparam int unsigned LOG_L = NODE_W - 1;
  localparam int unsigned LW    = (LOG_L > 0) ? LOG_L : 1;
  localparam int unsigned LVL_W = $clog2(LOG_L + 2);
  localparam int unsigned AB_W  = NODE_W + 1;
  localparam int unsigned BW    = rxpqt_pkg::BND_W;
  localparam logic [BW-1:0] LEAVES_X = BW'(LEAVES);
  localparam logic [BW-1:0] LMASK    = BW'(LEAVES - 1);
  localparam logic [LVL_W-1:0] LVL_LEAF = LVL_W'(LOG_L);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_WALK, S_RNG_A, S_RNG_B, S_DRAIN, S_FIN
  } state_e;

  typedef enum logic [1:0] {SEG_A, SEG_B, SEG_LEAF} seg_e;

  typedef enum logic [1:0] {PH_TOP, PH_SIB, PH_CHILD} phase_e;

  state_e                          state_q, state_d;
  seg_e                            seg_q, seg_d;
  phase_e                          ph_q, ph_d;
  logic [NODE_W-1:0]               cur_q, cur_d;
  logic [LW-1:0]                   dir_q, dir_d;
  logic [LW-1:0]                   srem_q, srem_d;
  logic [LVL_W-1:0]                lvl_q, lvl_d;
  logic [AB_W-1:0]                 a_q, a_d;
  logic [AB_W-1:0]                 b_q, b_d;
  logic [LW-1:0]                   re_low_q, re_low_d;
  logic [rxpqt_pkg::ACTION_W-1:0]  act_q, act_d;
  logic [rxpqt_pkg::VALUE_W-1:0]   value_q, value_d;
  logic                            status_q, status_d;
  logic [NODE_W-1:0]               init_q, init_d;

  logic [BW-1:0]                   used_x, bound, rb_x, re_x, ix_x;
  logic                            ok_apply, ok_pt;
  logic                            dbit, stop_root, stop_child, wdone;
  logic [LW-1:0]                   dir_sh, srem_sh;
  logic [NODE_W-1:0]               child, sib;
  logic [AB_W-1:0]                 b_n;
  rxpqt_pkg::op_kind_e             end_kind;

  assign used_x   = BW'(used_size_i);
  assign bound    = (used_x < LEAVES_X) ? used_x : LEAVES_X;
  assign rb_x     = BW'(req_i.range_begin);
  assign re_x     = BW'(req_i.range_end);
  assign ix_x     = BW'(req_i.index);
  assign ok_apply = (rb_x < bound) && (re_x <= bound) && (rb_x <= re_x);
  assign ok_pt    = ix_x < bound;

  assign dbit       = dir_q[LW-1];
  assign dir_sh     = dir_q << 1;
  assign srem_sh    = srem_q << 1;
  assign child      = NODE_W'({cur_q, dbit});
  assign sib        = NODE_W'({cur_q, ~dbit});
  assign stop_root  = (seg_q == SEG_LEAF) ? (LOG_L == 0) : (srem_q == '0);
  assign stop_child = (seg_q == SEG_LEAF) ? ((lvl_q + LVL_W'(1)) == LVL_LEAF)
                                          : (srem_sh == '0);
  assign b_n        = b_q[0] ? (b_q - AB_W'(1)) : b_q;

  always_comb begin
    end_kind = rxpqt_pkg::OP_END;
    if (seg_q == SEG_LEAF) begin
      case (act_q)
        rxpqt_pkg::ACT_SET:   end_kind = rxpqt_pkg::OP_SET;
        rxpqt_pkg::ACT_GET:   end_kind = rxpqt_pkg::OP_GET;
        rxpqt_pkg::ACT_CLEAR: end_kind = rxpqt_pkg::OP_ZERO;
        default:              end_kind = rxpqt_pkg::OP_END;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    seg_d    = seg_q;
    ph_d     = ph_q;
    cur_d    = cur_q;
    dir_d    = dir_q;
    srem_d   = srem_q;
    lvl_d    = lvl_q;
    a_d      = a_q;
    b_d      = b_q;
    re_low_d = re_low_q;
    act_d    = act_q;
    value_d  = value_q;
    status_d = status_q;
    init_d   = init_q;
    op_o     = '{vld: 1'b0, kind: rxpqt_pkg::OP_ZERO, clr: 1'b0};
    addr_o   = cur_q;
    wdone    = 1'b0;

    case (state_q)
      S_INIT: begin
        op_o.vld  = 1'b1;
        op_o.kind = rxpqt_pkg::OP_ZERO;
        addr_o    = init_q;
        init_d    = init_q + NODE_W'(1);
        if (init_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          op_o.clr = 1'b1;
          act_d    = req_i.action;
          value_d  = req_i.value;
          ph_d     = PH_TOP;
          cur_d    = NODE_W'(1);
          lvl_d    = '0;
          a_d      = AB_W'(LEAVES_X + rb_x);
          b_d      = AB_W'(LEAVES_X + re_x);
          re_low_d = LW'(re_x & LMASK);
          if (req_i.action == rxpqt_pkg::ACT_APPLY) begin
            status_d = !ok_apply;
            seg_d    = SEG_A;
            dir_d    = LW'(rb_x & LMASK);
            srem_d   = LW'(rb_x & LMASK);
            state_d  = ok_apply ? S_WALK : S_FIN;
          end else begin
            status_d = !ok_pt;
            seg_d    = SEG_LEAF;
            dir_d    = LW'(ix_x & LMASK);
            srem_d   = LW'(ix_x & LMASK);
            state_d  = ok_pt ? S_WALK : S_FIN;
          end
        end
      end
      S_WALK: begin
        op_o.vld = 1'b1;
        case (ph_q)
          PH_TOP: begin
            addr_o    = NODE_W'(1);
            op_o.kind = stop_root ? end_kind : rxpqt_pkg::OP_PATH;
            wdone     = stop_root;
            ph_d      = PH_SIB;
          end
          PH_SIB: begin
            addr_o    = sib;
            op_o.kind = rxpqt_pkg::OP_SIB;
            ph_d      = PH_CHILD;
          end
          PH_CHILD: begin
            addr_o    = child;
            op_o.kind = stop_child ? end_kind : rxpqt_pkg::OP_PATH;
            wdone     = stop_child;
            cur_d     = child;
            dir_d     = dir_sh;
            srem_d    = srem_sh;
            lvl_d     = lvl_q + LVL_W'(1);
            ph_d      = PH_SIB;
          end
          default: begin
            op_o.vld = 1'b0;
            ph_d     = PH_TOP;
          end
        endcase
        if (wdone) begin
          case (seg_q)
            SEG_A: begin
              if (re_low_q == '0) begin
                state_d = S_RNG_A;
              end else begin
                seg_d  = SEG_B;
                ph_d   = PH_TOP;
                cur_d  = NODE_W'(1);
                lvl_d  = '0;
                dir_d  = re_low_q & (re_low_q - LW'(1));
                srem_d = re_low_q;
              end
            end
            SEG_B:   state_d = S_RNG_A;
            default: state_d = S_DRAIN;
          endcase
        end
      end
      S_RNG_A: begin
        if (a_q >= b_q) begin
          state_d = S_DRAIN;
        end else begin
          if (a_q[0]) begin
            op_o.vld  = 1'b1;
            op_o.kind = rxpqt_pkg::OP_VAL;
            addr_o    = NODE_W'(a_q);
            a_d       = a_q + AB_W'(1);
          end
          state_d = S_RNG_B;
        end
      end
      S_RNG_B: begin
        if (b_q[0]) begin
          op_o.vld  = 1'b1;
          op_o.kind = rxpqt_pkg::OP_VAL;
          addr_o    = NODE_W'(b_n);
        end
        a_d     = a_q >> 1;
        b_d     = b_n >> 1;
        state_d = S_RNG_A;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      seg_q    <= SEG_A;
      ph_q     <= PH_TOP;
      cur_q    <= NODE_W'(1);
      dir_q    <= '0;
      srem_q   <= '0;
      lvl_q    <= '0;
      a_q      <= '0;
      b_q      <= '0;
      re_low_q <= '0;
      act_q    <= '0;
      value_q  <= '0;
      status_q <= 1'b0;
      init_q   <= '0;
    end else begin
      state_q  <= state_d;
      seg_q    <= seg_d;
      ph_q     <= ph_d;
      cur_q    <= cur_d;
      dir_q    <= dir_d;
      srem_q   <= srem_d;
      lvl_q    <= lvl_d;
      a_q      <= a_d;
      b_q      <= b_d;
      re_low_q <= re_low_d;
      act_q    <= act_d;
      value_q  <= value_d;
      status_q <= status_d;
      init_q   <= init_d;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign value_o     = value_q;
  assign done_o      = (state_q == S_FIN);
  assign status_o    = status_q;

endmodule

FILE: rtl/core/range_xor_point_query_tree.sv
// Range XOR point query tree: a dual segment tree of 32-bit XOR tags over
// LEAVES positions, kept in one memory of 2*LEAVES words. After reset the block
// runs a clearing pass, one word a cycle, before it takes its first
// transaction. The tree logic reads and writes one node per op: a set, get
// or clear walks the leaf path; an apply makes one or two boundary walks and
// then a cover loop, level by level. A rejected transaction goes straight to
// its response and leaves the tree alone. One transaction is in work at a
// time; the response register lets the next one enter while a response waits.
// Depends on rxpqt_pkg, rxpqt_if, rxpqt_mem, rxpqt_exec and rxpqt_seq.
module range_xor_point_query_tree #(
  parameter int unsigned LEAVES = rxpqt_pkg::LEAVES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rxpqt_req_if.sink                      req_i,
  rxpqt_rsp_if.source                    rsp_o,
  input  logic                           cfg_we_i,
  input  logic [rxpqt_pkg::USED_W-1:0]   cfg_wdata_i
);

  localparam int unsigned NODE_W = $clog2(LEAVES) + 1;

  logic [rxpqt_pkg::USED_W-1:0]    used_size_q;
  rxpqt_pkg::op_ctl_t              op;
  logic [NODE_W-1:0]               raddr;
  logic [NODE_W-1:0]               waddr;
  logic                            we;
  logic [rxpqt_pkg::VALUE_W-1:0]   wdata;
  logic [rxpqt_pkg::VALUE_W-1:0]   rdata;
  logic [rxpqt_pkg::VALUE_W-1:0]   value;
  logic [rxpqt_pkg::VALUE_W-1:0]   read_value;
  logic                            done;
  logic                            status;
  logic                            load;
  logic                            rsp_vld_q;
  logic [rxpqt_pkg::VALUE_W-1:0]   rsp_read_q;
  logic                            rsp_status_q;

  rxpqt_seq #(
    .LEAVES (LEAVES),
    .NODE_W (NODE_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .used_size_i (used_size_q),
    .req_i       (req_i),
    .op_o        (op),
    .addr_o      (raddr),
    .value_o     (value),
    .done_o      (done),
    .status_o    (status),
    .load_i      (load)
  );

  rxpqt_mem #(
    .NODE_W (NODE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rxpqt_exec #(
    .NODE_W (NODE_W)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .addr_i       (raddr),
    .value_i      (value),
    .rdata_i      (rdata),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .read_value_o (read_value)
  );

  assign load = done && (!rsp_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= rxpqt_pkg::USED_RST;
      rsp_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        used_size_q <= cfg_wdata_i;
      end
      if (load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_read_q   <= read_value;
      rsp_status_q <= status;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.read_value = rsp_read_q;
  assign rsp_o.status     = rsp_status_q;

endmodule

FILE: tb/sv/range_xor_point_query_tree_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for range_xor_point_query_tree: random and directed range XOR,
// set, get and clear transactions, checked against a tree of XOR tags kept here.
// Depends on rxpqt_pkg, rxpqt_if and the block's RTL.
module range_xor_point_query_tree_tb;
  import rxpqt_pkg::*;

  localparam int unsigned LEAVES = LEAVES_DEF;
  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int          LIMIT  = 1000000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [RB_W-1:0]     rb;
    logic [RE_W-1:0]     re;
    logic [IDX_W-1:0]    idx;
    logic [VALUE_W-1:0]  val;
  } tree_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] rd;
    logic               st;
  } tree_rsp_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [USED_W-1:0]  cfg_wdata_i;

  rxpqt_req_if req_if();
  rxpqt_rsp_if rsp_if();

  range_xor_point_query_tree #(.LEAVES(LEAVES)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [VALUE_W-1:0] tags [0:NODES-1];
  int unsigned        used_model;
  tree_op_t           req_backlog [$];
  tree_rsp_t          rsp_due [$];
  tree_op_t           on_bus;
  tree_rsp_t          want;
  int unsigned        n_sent;
  int unsigned        n_taken;
  int unsigned        mismatches;
  int unsigned        gap_left;
  int unsigned        stall_left;
  bit                 gaps_on;
  int                 cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned bound_of();
    return (used_model < LEAVES) ? used_model : LEAVES;
  endfunction

  function automatic int unsigned bit_len(int unsigned x);
    int unsigned w;
    w = 0;
    while (x != 0) begin
      w++;
      x >>= 1;
    end
    return w;
  endfunction

  function automatic int unsigned drop_low_zeros(int unsigned x);
    if (x == 0) return 0;
    while ((x & 1) == 0) x >>= 1;
    return x;
  endfunction

  // Push tags from the root down to the parent of node n.
  function automatic void push_tags(int unsigned n);
    int unsigned p;
    if (n >= NODES) return;
    for (int d = int'(bit_len(n)) - 1; d > 0; d--) begin
      p = n >> d;
      if (tags[p] != '0) begin
        tags[2*p]   ^= tags[p];
        tags[2*p+1] ^= tags[p];
        tags[p]     = '0;
      end
    end
  endfunction

  function automatic tree_rsp_t tree_step(tree_op_t op);
    tree_rsp_t   rsp;
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    int unsigned leaf;
    lim    = bound_of();
    rsp.rd = '0;
    rsp.st = 1'b0;
    if (op.action == ACT_APPLY) begin
      if (op.rb < lim && op.re <= lim && op.rb <= op.re) begin
        lo = op.rb + LEAVES;
        hi = op.re + LEAVES;
        push_tags(drop_low_zeros(lo));
        push_tags(drop_low_zeros(hi) - 1);
        while (lo < hi) begin
          if (lo & 1) begin
            tags[lo] ^= op.val;
            lo++;
          end
          if (hi & 1) begin
            hi--;
            tags[hi] ^= op.val;
          end
          lo >>= 1;
          hi >>= 1;
        end
      end else begin
        rsp.st = 1'b1;
      end
    end else if (op.idx < lim) begin
      leaf = op.idx + LEAVES;
      push_tags(leaf);
      case (op.action)
        ACT_SET: begin
          tags[leaf] = op.val;
        end
        ACT_GET: begin
          rsp.rd = tags[leaf];
        end
        default: begin
          tags[leaf] = '0;
        end
      endcase
    end else begin
      rsp.st = 1'b1;
    end
    return rsp;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic tree_op_t mk(logic [ACTION_W-1:0] action, int unsigned rb,
                                  int unsigned re, int unsigned idx,
                                  logic [VALUE_W-1:0] val);
    tree_op_t op;
    op.action = action;
    op.rb     = RB_W'(rb);
    op.re     = RE_W'(re);
    op.idx    = IDX_W'(idx);
    op.val    = val;
    return op;
  endfunction

  function automatic tree_op_t rand_op(int unsigned lim);
    tree_op_t    op;
    int unsigned r;
    int unsigned span;
    int unsigned hot;
    op.action = ACTION_W'($urandom_range(0, 3));
    op.rb     = RB_W'($urandom);
    op.re     = RE_W'($urandom);
    op.idx    = IDX_W'($urandom);
    op.val    = pick_value();
    if (lim == 0 || $urandom_range(0, 99) < 8) return op;
    hot = (lim < 16) ? lim : 16;
    r = $urandom_range(0, 99);
    op.action = (r < 35) ? ACT_APPLY : (r < 50) ? ACT_SET : (r < 85) ? ACT_GET : ACT_CLEAR;
    if (op.action == ACT_APPLY) begin
      op.rb = RB_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, hot - 1)
                                                 : $urandom_range(0, lim - 1));
      span = lim - op.rb;
      r = $urandom_range(0, 9);
      if (r < 2) op.re = RE_W'(op.rb);
      else if (r < 6) op.re = RE_W'(op.rb + $urandom_range(1, (span < 8) ? span : 8));
      else op.re = RE_W'($urandom_range(op.rb, lim));
    end else begin
      op.idx = IDX_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, hot - 1)
                                                  : $urandom_range(0, lim - 1));
    end
    return op;
  endfunction

  task automatic enqueue(tree_op_t op);
    req_backlog.insert(req_backlog.size(), op);
    n_sent++;
  endtask

  task automatic add_bound_edges(int unsigned lim);
    if (lim < LEAVES) begin
      enqueue(mk(ACT_APPLY, lim, lim, 0, 32'h1));
      enqueue(mk(ACT_GET, 0, 0, lim, '0));
    end
    if (lim > 0) begin
      enqueue(mk(ACT_GET, 0, 0, lim - 1, '0));
      enqueue(mk(ACT_APPLY, lim - 1, lim, 0, $urandom));
      enqueue(mk(ACT_SET, 0, 0, lim - 1, $urandom));
      enqueue(mk(ACT_GET, 0, 0, lim - 1, '0));
    end
  endtask

  task automatic write_used(logic [USED_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    used_model  = 32'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (n_taken != n_sent || rsp_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rsp_due.insert(rsp_due.size(), tree_step(on_bus));
        n_taken++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          on_bus = req_backlog.pop_front();
          req_if.valid       <= 1'b1;
          req_if.action      <= on_bus.action;
          req_if.range_begin <= on_bus.rb;
          req_if.range_end   <= on_bus.re;
          req_if.index       <= on_bus.idx;
          req_if.value       <= on_bus.val;
          gap_left = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: read_value %h status %0d",
                     rsp_if.read_value, rsp_if.status);
        end else begin
          want = rsp_due.pop_front();
          if (rsp_if.read_value !== want.rd || rsp_if.status !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: read_value exp %h got %h, status exp %0d got %0d",
                       want.rd, rsp_if.read_value, want.st, rsp_if.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [USED_W-1:0] sizes [7];
    int unsigned       counts [7];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_APPLY;
    req_if.range_begin = '0;
    req_if.range_end   = '0;
    req_if.index       = '0;
    req_if.value       = '0;
    rsp_if.ready       = 1'b0;
    n_sent             = 0;
    n_taken            = 0;
    mismatches         = 0;
    cycles             = 0;
    gaps_on            = 1'b1;
    used_model         = 32'(USED_RST);
    for (int n = 0; n < NODES; n++) tags[n] = '0;
    sizes[0] = USED_RST;  counts[0] = 250;
    sizes[1] = 11'd1;     counts[1] = 40;
    sizes[2] = 11'd0;     counts[2] = 20;
    sizes[3] = 11'd2047;  counts[3] = 200;
    sizes[4] = USED_W'($urandom_range(2, 1023));  counts[4] = 150;
    sizes[5] = USED_W'($urandom_range(2, 64));    counts[5] = 150;
    sizes[6] = USED_RST;  counts[6] = 140;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_used(USED_RST);
    @(negedge clk_i);
    enqueue(mk(ACT_GET, 0, 0, 0, '0));
    enqueue(mk(ACT_GET, 0, 0, 1023, '0));
    enqueue(mk(ACT_APPLY, 0, 1024, 0, '1));
    enqueue(mk(ACT_GET, 0, 0, 0, '0));
    enqueue(mk(ACT_GET, 0, 0, 512, '0));
    enqueue(mk(ACT_GET, 0, 0, 1023, '0));
    enqueue(mk(ACT_APPLY, 5, 5, 0, 32'hDEAD_BEEF));
    enqueue(mk(ACT_APPLY, 1023, 1023, 0, 32'h0000_0001));
    enqueue(mk(ACT_APPLY, 10, 9, 0, 32'h5555_5555));
    enqueue(mk(ACT_APPLY, 1000, 1024, 1023, 32'h1234_5678));
    enqueue(mk(ACT_SET, 0, 0, 3, 32'hA5A5_A5A5));
    enqueue(mk(ACT_GET, 0, 0, 3, '0));
    enqueue(mk(ACT_CLEAR, 0, 0, 3, '1));
    enqueue(mk(ACT_GET, 0, 0, 3, '0));
    enqueue(mk(ACT_APPLY, 1, 1023, 0, 32'h0F0F_0F0F));
    enqueue(mk(ACT_GET, 0, 0, 0, '0));
    enqueue(mk(ACT_GET, 0, 0, 1, '0));
    enqueue(mk(ACT_GET, 0, 0, 1022, '0));
    enqueue(mk(ACT_GET, 0, 0, 1023, '0));
    enqueue(mk(ACT_SET, 0, 0, 1023, '1));
    enqueue(mk(ACT_GET, 0, 0, 1023, '0));
    enqueue(mk(ACT_SET, 0, 0, 0, '0));
    enqueue(mk(ACT_GET, 0, 0, 0, '0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      gaps_on = (ph != 3);
      write_used(sizes[ph]);
      @(negedge clk_i);
      add_bound_edges(bound_of());
      repeat (counts[ph]) enqueue(rand_op(bound_of()));
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
